// ===== design/ffaa_pkg.sv =====
package ffaa_pkg;

    // arena geometry: granules of 8 bytes, link value ARENA_GRANULES ends the list
    localparam int ARENA_GRANULES = 512;
    localparam int LINK_W         = 10;
    localparam int ADDR_W         = 9;
    localparam int SIZE_W         = 11;

    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(ARENA_GRANULES);
    localparam logic [13:0]       GRAN_MASK = 14'h3ff8;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_NOSPACE = 3'd1;
    localparam t_status ST_DOUBLE  = 3'd2;
    localparam t_status ST_OVERLAP = 3'd3;
    localparam t_status ST_BAD     = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // one free-list entry: link to next chunk and length in granules
    typedef struct packed {
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] len;
    } t_chunk;

    // one request to the chunk store: a write and a read
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_chunk            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

endpackage

// ===== design/first_fit_arena_allocator.sv =====
// First-fit allocator over a 4096-byte arena of 8-byte granules.
// Command channel: an item (i_action, i_req_bytes, i_block_offset) is taken
// at a rising edge with start high and busy low. busy stays high until the
// item's result has been formed.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_granted_offset and o_free_bytes; the receiver cannot stall it, so the
// result must be captured in that cycle.
// Walk: a bad request goes through state S_BAD to its result. An allocate
// visits chunks on the free list until one fits; a free passes the chunks
// before the freed address, then checks for a double free or an overlap
// and, if ok, links and writes the freed chunk. Every visit is one read of
// the chunk store, which has one write port and one read port.
// Reset: synchronous, active low. The first cycle after reset writes the
// single whole-arena chunk into entry 0 of the store (busy is high for that
// one cycle); after it the block is idle with all 4096 bytes free.
module first_fit_arena_allocator
    import ffaa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [12:0] i_req_bytes,
    input  logic [11:0] i_block_offset,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [11:0] o_granted_offset,
    output logic [12:0] o_free_bytes
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_BAD, S_A_TEST, S_A_CHK, S_A_LINK,
        S_F_TEST, S_F_ADV, S_F_CHK, S_F_LINK, S_F_WR
    } t_state;

    t_state            r_state;
    logic [LINK_W-1:0] r_head, r_free, r_cur, r_prev, r_pnext, r_plen, r_steps;
    logic [LINK_W-1:0] r_succ, r_bnext, r_blen, r_base;
    logic [SIZE_W-1:0] r_g;
    logic [ADDR_W-1:0] r_og;
    logic              r_join;
    logic              r_done;
    t_status           r_status;
    logic [11:0]       r_gofs;
    logic [12:0]       r_fbytes;

    t_store_req        store_req;
    t_chunk            rd;

    logic [13:0]       req_round;
    logic [SIZE_W-1:0] in_g;
    logic [SIZE_W-1:0] in_end;
    logic              in_bad;
    logic              a_fit, a_split;
    logic [SIZE_W-1:0] a_rest;
    logic [LINK_W-1:0] a_succ, a_take, a_free;
    logic              f_walk, f_double, f_over, f_join;
    logic [LINK_W-1:0] f_cur, og_ext;
    logic [SIZE_W-1:0] f_pend;
    logic [LINK_W-1:0] b_base, b_len0, b_next0;
    logic              b_merge;

    ffaa_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (rd)
    );

    // request decode
    always_comb begin
        req_round = ({1'b0, i_req_bytes} + 14'd7) & GRAN_MASK;
        in_g      = req_round[13:3];
        in_end    = {2'b00, i_block_offset[11:3]} + in_g;
        in_bad    = (in_g == '0) ||
                    ((i_action == ACT_FREE) &&
                     ((i_block_offset[2:0] != 3'd0) || (in_end > SIZE_W'(ARENA_GRANULES))));
    end

    // allocate: fit test and split of the chunk just read
    always_comb begin
        og_ext  = {1'b0, r_og};
        a_fit   = {1'b0, rd.len} >= r_g;
        a_rest  = {1'b0, r_cur} + r_g;
        a_split = !(({1'b0, rd.len} == r_g) || (a_rest >= SIZE_W'(ARENA_GRANULES)));
        a_succ  = a_split ? a_rest[LINK_W-1:0] : rd.nxt;
        a_take  = (r_g <= {1'b0, r_free}) ? r_g[LINK_W-1:0] : r_free;
        a_free  = r_free - a_take;
    end

    // free: walk bound, neighbour checks and coalescing
    always_comb begin
        f_walk   = (r_cur < LINK_END) && (r_steps < LINK_END) && (og_ext > r_cur);
        f_cur    = ((r_cur > LINK_END) || ((r_cur < LINK_END) && (og_ext > r_cur)))
                   ? LINK_END : r_cur;
        f_pend   = {1'b0, r_prev} + {1'b0, r_plen};
        f_double = (f_cur < LINK_END) && (og_ext == f_cur);
        f_over   = ((r_prev < LINK_END) && (f_pend > {2'b00, r_og})) ||
                   ((f_cur < LINK_END) && (({2'b00, r_og} + r_g) > {1'b0, f_cur}));
        f_join   = (r_prev < LINK_END) && (f_pend == {2'b00, r_og});
        b_base   = r_join ? r_prev : og_ext;
        b_len0   = r_join ? (r_plen + r_g[LINK_W-1:0]) : r_g[LINK_W-1:0];
        b_next0  = r_join ? r_pnext : r_cur;
        b_merge  = (r_cur < LINK_END) &&
                   (({1'b0, b_base} + {1'b0, b_len0}) == {1'b0, r_cur});
    end

    // drive the chunk store from the sequencer state
    always_comb begin
        store_req = '0;
        case (r_state)
            S_INIT: begin
                store_req.we    = 1'b1;
                store_req.waddr = '0;
                store_req.wdata = '{nxt: LINK_END, len: LINK_END};
            end
            S_A_TEST: begin
                store_req.re    = 1'b1;
                store_req.raddr = r_cur[ADDR_W-1:0];
            end
            S_A_CHK: begin
                store_req.we    = a_fit && a_split;
                store_req.waddr = a_rest[ADDR_W-1:0];
                store_req.wdata = '{nxt: rd.nxt, len: rd.len - r_g[LINK_W-1:0]};
            end
            S_A_LINK: begin
                store_req.we    = r_prev < LINK_END;
                store_req.waddr = r_prev[ADDR_W-1:0];
                store_req.wdata = '{nxt: r_succ, len: r_plen};
            end
            S_F_TEST: begin
                store_req.re    = f_walk;
                store_req.raddr = r_cur[ADDR_W-1:0];
            end
            S_F_CHK: begin
                store_req.re    = f_cur < LINK_END;
                store_req.raddr = f_cur[ADDR_W-1:0];
            end
            S_F_LINK: begin
                store_req.we    = !r_join && (r_prev < LINK_END);
                store_req.waddr = r_prev[ADDR_W-1:0];
                store_req.wdata = '{nxt: og_ext, len: r_plen};
            end
            S_F_WR: begin
                store_req.we    = 1'b1;
                store_req.waddr = r_base[ADDR_W-1:0];
                store_req.wdata = '{nxt: r_bnext, len: r_blen};
            end
            default: begin
                store_req = '0;
            end
        endcase
    end

    // sequencer, list registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_head  <= '0;
            r_free  <= LINK_END;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_g     <= in_g;
                        r_og    <= i_block_offset[11:3];
                        r_cur   <= r_head;
                        r_prev  <= LINK_END;
                        r_steps <= '0;
                        if (in_bad) begin
                            r_state <= S_BAD;
                        end else if (i_action == ACT_ALLOC) begin
                            r_state <= S_A_TEST;
                        end else begin
                            r_state <= S_F_TEST;
                        end
                    end
                end
                S_BAD: begin
                    r_done   <= 1'b1;
                    r_status <= ST_BAD;
                    r_gofs   <= '0;
                    r_fbytes <= {r_free, 3'b000};
                    r_state  <= S_IDLE;
                end
                S_A_TEST: begin
                    if ((r_cur < LINK_END) && (r_steps < LINK_END)) begin
                        r_state <= S_A_CHK;
                    end else begin
                        r_done   <= 1'b1;
                        r_status <= ST_NOSPACE;
                        r_gofs   <= '0;
                        r_fbytes <= {r_free, 3'b000};
                        r_state  <= S_IDLE;
                    end
                end
                S_A_CHK: begin
                    if (a_fit) begin
                        r_succ  <= a_succ;
                        r_state <= S_A_LINK;
                    end else begin
                        r_prev  <= r_cur;
                        r_plen  <= rd.len;
                        r_pnext <= rd.nxt;
                        r_cur   <= rd.nxt;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_A_TEST;
                    end
                end
                S_A_LINK: begin
                    if (r_prev >= LINK_END) begin
                        r_head <= r_succ;
                    end
                    r_free   <= a_free;
                    r_done   <= 1'b1;
                    r_status <= ST_OK;
                    r_gofs   <= {r_cur[ADDR_W-1:0], 3'b000};
                    r_fbytes <= {a_free, 3'b000};
                    r_state  <= S_IDLE;
                end
                S_F_TEST: begin
                    r_state <= f_walk ? S_F_ADV : S_F_CHK;
                end
                S_F_ADV: begin
                    r_prev  <= r_cur;
                    r_plen  <= rd.len;
                    r_pnext <= rd.nxt;
                    r_cur   <= rd.nxt;
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_F_TEST;
                end
                S_F_CHK: begin
                    r_cur  <= f_cur;
                    r_join <= f_join;
                    if (f_double || f_over) begin
                        r_done   <= 1'b1;
                        r_status <= f_double ? ST_DOUBLE : ST_OVERLAP;
                        r_gofs   <= '0;
                        r_fbytes <= {r_free, 3'b000};
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_F_LINK;
                    end
                end
                S_F_LINK: begin
                    if (!r_join && (r_prev >= LINK_END)) begin
                        r_head <= og_ext;
                    end
                    r_base  <= b_base;
                    r_blen  <= b_merge ? (b_len0 + rd.len) : b_len0;
                    r_bnext <= b_merge ? rd.nxt : b_next0;
                    r_state <= S_F_WR;
                end
                S_F_WR: begin
                    r_free   <= r_free + r_g[LINK_W-1:0];
                    r_done   <= 1'b1;
                    r_status <= ST_OK;
                    r_gofs   <= '0;
                    r_fbytes <= {r_free + r_g[LINK_W-1:0], 3'b000};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_offset = r_gofs;
    assign o_free_bytes     = r_fbytes;

`ifndef NO_ASSERTIONS
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_granted_offset == '0))
        else $error("granted offset set on a failed item");

    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not hold busy");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= LINK_END)
        else $error("free granule count beyond arena");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while sequencer still busy");
`endif

endmodule

// ===== design/ffaa_store.sv =====
module ffaa_store
    import ffaa_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_chunk     o_rdata
);

    t_chunk r_mem [ARENA_GRANULES];
    t_chunk r_rdata;

    // write one entry and read one entry, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
